### sv/accumulator_alu_with_register_file_assert.svh
// assertion macros used by the port-level checker in sv/accalu_checker.sv
// ASRT_IMP: same-cycle implication, ASRT_NXT: next-cycle implication
// dis is the disable condition, 1'b0 keeps the property alive through reset
`ifndef ACCUMULATOR_ALU_WITH_REGISTER_FILE_ASSERT_SVH
`define ACCUMULATOR_ALU_WITH_REGISTER_FILE_ASSERT_SVH

`define ASRT_IMP(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASRT_NXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/accalu_pkg.sv
// ----------------------------------------------------------------------------
// accalu_pkg
// types and codes shared by the accumulator alu and its register file
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package accalu_pkg;

  // function codes
  localparam logic [3:0] FUNC_ADD  = 4'd0;
  localparam logic [3:0] FUNC_ADC  = 4'd1;
  localparam logic [3:0] FUNC_SUB  = 4'd2;
  localparam logic [3:0] FUNC_SBB  = 4'd3;
  localparam logic [3:0] FUNC_AND  = 4'd4;
  localparam logic [3:0] FUNC_XOR  = 4'd5;
  localparam logic [3:0] FUNC_OR   = 4'd6;
  localparam logic [3:0] FUNC_CMP  = 4'd7;
  localparam logic [3:0] FUNC_INC  = 4'd8;
  localparam logic [3:0] FUNC_DEC  = 4'd9;
  localparam logic [3:0] FUNC_RLC  = 4'd10;
  localparam logic [3:0] FUNC_RRC  = 4'd11;
  localparam logic [3:0] FUNC_RAL  = 4'd12;
  localparam logic [3:0] FUNC_RAR  = 4'd13;
  localparam logic [3:0] FUNC_LOAD = 4'd14;

  // register indexes
  localparam logic [2:0] REG_A   = 3'd0;
  localparam logic [2:0] REG_MEM = 3'd7;  // memory slot, no storage

  localparam int RF_DEPTH = 7;

  // upper byte of the 16-bit intermediate, nonzero on carry or borrow
  localparam logic [15:0] HIGH_MASK = 16'hff00;

  typedef struct packed {
    logic [3:0] func;
    logic       use_operand;
    logic [2:0] reg_index;
    logic [7:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [7:0] accumulator;
    logic [7:0] alu_result;
    logic       carry_flag;
    logic       zero_flag;
    logic       sign_flag;
    logic       parity_flag;
  } out_item_t;

  typedef struct packed {
    logic carry;
    logic zero;
    logic sign;
    logic parity;
  } flags_t;

  // state update from the alu to the register file
  typedef struct packed {
    logic       reg_we;
    logic [2:0] reg_idx;
    logic [7:0] reg_data;
    flags_t     flags;
  } rf_wr_t;

endpackage

### sv/accalu_rf.sv
// ----------------------------------------------------------------------------
// accalu_rf
// seven-entry register file plus condition flags, one write port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accalu_rf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          rd_idx,
  output logic [7:0]          rd_data,
  output logic [7:0]          acc,
  output accalu_pkg::flags_t  flags,
  input  logic                we,
  input  accalu_pkg::rf_wr_t  wr
);
  import accalu_pkg::*;

  logic [7:0] regs_r [RF_DEPTH];
  flags_t     flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RF_DEPTH; i++) begin
        regs_r[i] <= 8'h00;
      end
      flags_r <= '0;
    end else if (we) begin
      if (wr.reg_we && (wr.reg_idx != REG_MEM)) begin
        regs_r[wr.reg_idx] <= wr.reg_data;
      end
      flags_r <= wr.flags;
    end
  end

  assign rd_data = (rd_idx != REG_MEM) ? regs_r[rd_idx] : 8'h00;
  assign acc     = regs_r[REG_A];
  assign flags   = flags_r;

endmodule

### sv/accalu_alu.sv
// ----------------------------------------------------------------------------
// accalu_alu
// combinational execute: operation decode, arithmetic, flags and result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accalu_alu (
  input  accalu_pkg::in_item_t  item,
  input  logic [7:0]            acc,
  input  accalu_pkg::flags_t    flags,
  input  logic [7:0]            rd_data,
  output accalu_pkg::rf_wr_t    wr,
  output accalu_pkg::out_item_t result
);
  import accalu_pkg::*;

  logic [7:0]  reg_src;
  logic [7:0]  src;
  logic        ci;
  logic [15:0] add_t;
  logic [15:0] sub_t;
  logic [7:0]  res;
  logic        upd_zsp;
  flags_t      flags_n;
  logic        reg_we;
  logic [2:0]  reg_idx;

  // memory slot reads the operand byte
  assign reg_src = (item.reg_index == REG_MEM) ? item.operand : rd_data;
  assign src     = item.use_operand ? item.operand : reg_src;
  assign ci      = ((item.func == FUNC_ADC) || (item.func == FUNC_SBB)) & flags.carry;
  assign add_t   = {8'h00, acc} + {8'h00, src} + {15'd0, ci};
  assign sub_t   = {8'h00, acc} - {8'h00, src} - {15'd0, ci};

  always_comb begin
    res     = 8'h00;
    upd_zsp = 1'b0;
    flags_n = flags;
    reg_we  = 1'b0;
    reg_idx = REG_A;
    unique case (item.func) inside
      FUNC_ADD, FUNC_ADC: begin
        res           = add_t[7:0];
        flags_n.carry = |(add_t & HIGH_MASK);
        upd_zsp       = 1'b1;
        reg_we        = 1'b1;
      end
      FUNC_SUB, FUNC_SBB: begin
        res           = sub_t[7:0];
        flags_n.carry = |(sub_t & HIGH_MASK);
        upd_zsp       = 1'b1;
        reg_we        = 1'b1;
      end
      FUNC_CMP: begin
        res           = sub_t[7:0];
        flags_n.carry = |(sub_t & HIGH_MASK);
        upd_zsp       = 1'b1;
      end
      FUNC_AND, FUNC_XOR, FUNC_OR: begin
        if (item.func == FUNC_AND) begin
          res = acc & src;
        end else if (item.func == FUNC_XOR) begin
          res = acc ^ src;
        end else begin
          res = acc | src;
        end
        flags_n.carry = 1'b0;
        upd_zsp       = 1'b1;
        reg_we        = 1'b1;
      end
      FUNC_INC, FUNC_DEC: begin
        res     = (item.func == FUNC_INC) ? reg_src + 8'd1 : reg_src - 8'd1;
        upd_zsp = 1'b1;
        reg_we  = (item.reg_index != REG_MEM);
        reg_idx = item.reg_index;
      end
      FUNC_RLC: begin
        res           = {acc[6:0], acc[7]};
        flags_n.carry = acc[7];
        reg_we        = 1'b1;
      end
      FUNC_RRC: begin
        res           = {acc[0], acc[7:1]};
        flags_n.carry = acc[0];
        reg_we        = 1'b1;
      end
      FUNC_RAL: begin
        res           = {acc[6:0], flags.carry};
        flags_n.carry = acc[7];
        reg_we        = 1'b1;
      end
      FUNC_RAR: begin
        res           = {flags.carry, acc[7:1]};
        flags_n.carry = acc[0];
        reg_we        = 1'b1;
      end
      FUNC_LOAD: begin
        res     = item.operand;
        reg_we  = (item.reg_index != REG_MEM);
        reg_idx = item.reg_index;
      end
      default: begin
        res = 8'h00;  // no operation
      end
    endcase
    if (upd_zsp) begin
      flags_n.zero   = (res == 8'h00);
      flags_n.sign   = res[7];
      flags_n.parity = ~^res;
    end
  end

  assign wr.reg_we   = reg_we;
  assign wr.reg_idx  = reg_idx;
  assign wr.reg_data = res;
  assign wr.flags    = flags_n;

  assign result.accumulator = (reg_we && (reg_idx == REG_A)) ? res : acc;
  assign result.alu_result  = res;
  assign result.carry_flag  = flags_n.carry;
  assign result.zero_flag   = flags_n.zero;
  assign result.sign_flag   = flags_n.sign;
  assign result.parity_flag = flags_n.parity;

endmodule

### sv/accumulator_alu_with_register_file.sv
// ----------------------------------------------------------------------------
// accumulator_alu_with_register_file
// 8-bit accumulator alu on a seven-entry register file with four flags
// ----------------------------------------------------------------------------
//
//   channel | ports                          | payload
//   --------+--------------------------------+------------------------------
//   input   | in_valid, in_stall, in_data    | func, use_operand, reg_index,
//           |                                | operand
//   output  | out_valid, out_stall, out_data | accumulator, alu_result, flags
//
// one item per cycle sustained while the output is not stalled; out_valid rises
// as the result register takes the item; it transfers when the output is free
// the figure is set by the execute stage, which reads and writes the register
// file and flags in the same cycle, so each item sees its predecessor's state
// reset clears the register file, the flags and both valid registers at once
// an output stall holds the result register and stalls the input register
// only when that register is occupied
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accumulator_alu_with_register_file (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  accalu_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output accalu_pkg::out_item_t out_data
);
  import accalu_pkg::*;

  // input register
  logic      in_valid_r;
  in_item_t  in_item_r;

  // result register
  logic      out_valid_r;
  out_item_t out_item_r;

  // execute stage
  logic      fire;
  logic      in_xfer;
  logic [7:0] rd_data;
  logic [7:0] acc;
  flags_t    flags;
  rf_wr_t    wr;
  out_item_t result;

  // execute when an item is held and the result register can take it
  assign fire     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !fire;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r <= in_data;
    end
  end

  accalu_rf u_rf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (in_item_r.reg_index),
    .rd_data (rd_data),
    .acc     (acc),
    .flags   (flags),
    .we      (fire),
    .wr      (wr)
  );

  accalu_alu u_alu (
    .item    (in_item_r),
    .acc     (acc),
    .flags   (flags),
    .rd_data (rd_data),
    .wr      (wr),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

### sv/accalu_checker.sv
// ----------------------------------------------------------------------------
// accalu_checker
// port-level assertions for the accumulator alu, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "accumulator_alu_with_register_file_assert.svh"

module accalu_sva (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input accalu_pkg::out_item_t out_data
);
  import accalu_pkg::*;

  // no result right after reset
  `ASRT_NXT(a_rst_empty, clk, 1'b0, !rst_n, !out_valid)

  // an empty result register never backs up the input
  `ASRT_IMP(a_no_stall_empty, clk, !rst_n, in_valid && !out_valid, !in_stall)

  // a stalled result holds
  `ASRT_NXT(a_out_hold, clk, !rst_n, out_valid && out_stall,
            out_valid && $stable(out_data))

  // a set zero flag always comes with parity set and sign clear
  `ASRT_IMP(a_zsp_coherent, clk, !rst_n, out_valid && out_data.zero_flag,
            out_data.parity_flag && !out_data.sign_flag)

endmodule

bind accumulator_alu_with_register_file accalu_sva u_accalu_sva (.*);

### tb/accalu_checker.sv
// ----------------------------------------------------------------------------
// accalu_checker
// watches both channels of the accumulator alu, predicts each result from its
// own copy of the register file and flags, and compares field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accalu_checker
  import accalu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending_count,
  output int        result_count
);

  logic [7:0] model_regs [RF_DEPTH];
  flags_t     model_flags;
  out_item_t  expected_results [$];
  int         mismatches = 0;
  int         checked = 0;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    result_count  = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got %h expected %h",
                                checked, name, got, want));
    end
  endtask

  // memory slot reads the operand byte
  function automatic logic [7:0] reg_or_operand(input logic [2:0] idx,
                                                input logic [7:0] operand);
    if (idx == REG_MEM) return operand;
    return model_regs[idx];
  endfunction

  function automatic void update_zsp(input logic [7:0] v);
    model_flags.zero   = (v == 8'h00);
    model_flags.sign   = v[7];
    model_flags.parity = ~^v;
  endfunction

  // runs one operation on the model state and returns the result it shows
  function automatic out_item_t exec_alu_op(input in_item_t it);
    logic [7:0] acc;
    logic [7:0] src;
    logic [7:0] res;
    logic [8:0] wide;
    logic       cin;
    out_item_t  r;
    acc = model_regs[REG_A];
    cin = model_flags.carry;
    src = it.use_operand ? it.operand : reg_or_operand(it.reg_index, it.operand);
    res = 8'h00;
    case (it.func)
      FUNC_ADD, FUNC_ADC, FUNC_SUB, FUNC_SBB, FUNC_CMP: begin
        case (it.func)
          FUNC_ADD: wide = {1'b0, acc} + {1'b0, src};
          FUNC_ADC: wide = {1'b0, acc} + {1'b0, src} + {8'h00, cin};
          FUNC_SBB: wide = {1'b0, acc} - {1'b0, src} - {8'h00, cin};
          default:  wide = {1'b0, acc} - {1'b0, src};
        endcase
        res = wide[7:0];
        model_flags.carry = wide[8];
        update_zsp(res);
        if (it.func != FUNC_CMP) model_regs[REG_A] = res;
      end
      FUNC_AND, FUNC_XOR, FUNC_OR: begin
        if (it.func == FUNC_AND) res = acc & src;
        else if (it.func == FUNC_XOR) res = acc ^ src;
        else res = acc | src;
        model_regs[REG_A] = res;
        model_flags.carry = 1'b0;
        update_zsp(res);
      end
      FUNC_INC, FUNC_DEC: begin
        // carry kept, source select ignored
        res = reg_or_operand(it.reg_index, it.operand);
        res = (it.func == FUNC_INC) ? res + 8'd1 : res - 8'd1;
        if (it.reg_index != REG_MEM) model_regs[it.reg_index] = res;
        update_zsp(res);
      end
      FUNC_RLC: begin
        res = {acc[6:0], acc[7]};
        model_flags.carry = acc[7];
        model_regs[REG_A] = res;
      end
      FUNC_RRC: begin
        res = {acc[0], acc[7:1]};
        model_flags.carry = acc[0];
        model_regs[REG_A] = res;
      end
      FUNC_RAL: begin
        res = {acc[6:0], cin};
        model_flags.carry = acc[7];
        model_regs[REG_A] = res;
      end
      FUNC_RAR: begin
        res = {cin, acc[7:1]};
        model_flags.carry = acc[0];
        model_regs[REG_A] = res;
      end
      FUNC_LOAD: begin
        res = it.operand;
        if (it.reg_index != REG_MEM) model_regs[it.reg_index] = it.operand;
      end
      default: res = 8'h00;
    endcase
    r.accumulator = model_regs[REG_A];
    r.alu_result  = res;
    r.carry_flag  = model_flags.carry;
    r.zero_flag   = model_flags.zero;
    r.sign_flag   = model_flags.sign;
    r.parity_flag = model_flags.parity;
    return r;
  endfunction

  always @(posedge clk) begin : watch_proc
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < RF_DEPTH; i++) model_regs[i] = 8'h00;
      model_flags = '0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", out_data));
        end else begin
          want = expected_results.pop_front();
          check_field("accumulator", out_data.accumulator, want.accumulator);
          check_field("alu_result", out_data.alu_result, want.alu_result);
          check_field("carry", 8'(out_data.carry_flag), 8'(want.carry_flag));
          check_field("zero", 8'(out_data.zero_flag), 8'(want.zero_flag));
          check_field("sign", 8'(out_data.sign_flag), 8'(want.sign_flag));
          check_field("parity", 8'(out_data.parity_flag), 8'(want.parity_flag));
          checked++;
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(exec_alu_op(in_data));
    end
    fail_count    <= mismatches;
    pending_count <= expected_results.size();
    result_count  <= checked;
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the accumulator alu with register file: a directed
// pass over every function and corner, then random traffic, in part with bursty idle
// on both channels, checked by accalu_checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import accalu_pkg::*;

  // code outside the package range, decodes as no operation
  localparam logic [3:0] FUNC_NOP = 4'd15;

  // register file slots besides the accumulator
  localparam logic [2:0] REG_B = 3'd1;
  localparam logic [2:0] REG_C = 3'd2;
  localparam logic [2:0] REG_D = 3'd3;
  localparam logic [2:0] REG_H = 3'd5;
  localparam logic [2:0] REG_L = 3'd6;

  localparam int ITEM_COUNT   = 800;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES = 8;     // margin after the final drain

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic idle_on = 1'b0;  // gates idle bursts on both channels
  int   fail_count;
  int   pending_count;
  int   result_count;
  int   items_sent = 0;
  int   quiet_cycles = 0;
  int   stall_left = 0;

  always #10 clk = ~clk;

  accumulator_alu_with_register_file dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  accalu_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  function automatic in_item_t make_item(input logic [3:0] func, input logic use_op,
                                         input logic [2:0] idx,
                                         input logic [7:0] operand);
    in_item_t it;
    it.func        = func;
    it.use_operand = use_op;
    it.reg_index   = idx;
    it.operand     = operand;
    return it;
  endfunction

  // random item, extremes of the operand byte show up often
  function automatic in_item_t random_item();
    in_item_t it;
    it.func        = ($urandom_range(0, 49) == 0) ? FUNC_NOP : 4'($urandom_range(0, 14));
    it.use_operand = 1'($urandom_range(0, 1));
    it.reg_index   = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 7))
      0: it.operand = 8'h00;
      1: it.operand = 8'hff;
      2: it.operand = 8'h80;
      3: it.operand = 8'h7f;
      default: it.operand = 8'($urandom);
    endcase
    return it;
  endfunction

  // called at a rising edge; returns at the edge where the transfer happens
  task automatic send_item(input in_item_t item);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      // idle burst before this item
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // hold the input side until every predicted result has come out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // output stall bursts, started only while idling is on
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_count);
      $display("[accumulator_alu_with_register_file] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // seed the register file with corner values
    send_item(make_item(FUNC_LOAD, 1'b0, REG_B, 8'hff));
    send_item(make_item(FUNC_LOAD, 1'b0, REG_C, 8'h80));
    send_item(make_item(FUNC_LOAD, 1'b0, REG_D, 8'h01));
    send_item(make_item(FUNC_LOAD, 1'b0, REG_H, 8'h55));
    send_item(make_item(FUNC_LOAD, 1'b0, REG_L, 8'haa));
    send_item(make_item(FUNC_LOAD, 1'b0, REG_A, 8'hff));
    // ff + ff from a register, carry out of the 9-bit sum
    send_item(make_item(FUNC_ADD, 1'b0, REG_B, 8'h00));
    // add with carry in on a zero operand byte
    send_item(make_item(FUNC_ADC, 1'b1, REG_B, 8'h00));
    // subtract to zero, no borrow
    send_item(make_item(FUNC_SUB, 1'b1, REG_B, 8'hff));
    // 00 - 80 borrows
    send_item(make_item(FUNC_SBB, 1'b0, REG_C, 8'h00));
    // borrow in on a zero operand
    send_item(make_item(FUNC_SBB, 1'b1, REG_C, 8'h00));
    send_item(make_item(FUNC_AND, 1'b0, REG_H, 8'h00));
    send_item(make_item(FUNC_XOR, 1'b0, REG_L, 8'h00));
    send_item(make_item(FUNC_OR, 1'b1, REG_L, 8'h00));
    // compare accumulator with itself, a stays put
    send_item(make_item(FUNC_CMP, 1'b0, REG_A, 8'h00));
    // inc wraps ff to 00 with carry kept, dec lands on zero
    send_item(make_item(FUNC_INC, 1'b0, REG_B, 8'h00));
    send_item(make_item(FUNC_DEC, 1'b0, REG_D, 8'h00));
    // memory slot: dec and load compute but write nothing
    send_item(make_item(FUNC_DEC, 1'b0, REG_MEM, 8'h00));
    send_item(make_item(FUNC_LOAD, 1'b0, REG_MEM, 8'h5a));
    // memory slot as a register source reads the operand byte
    send_item(make_item(FUNC_ADD, 1'b0, REG_MEM, 8'h80));
    send_item(make_item(FUNC_RLC, 1'b0, REG_A, 8'h00));
    send_item(make_item(FUNC_RRC, 1'b0, REG_A, 8'h00));
    send_item(make_item(FUNC_RAL, 1'b0, REG_A, 8'h00));
    send_item(make_item(FUNC_RAR, 1'b0, REG_A, 8'h00));
    send_item(make_item(FUNC_NOP, 1'b1, REG_MEM, 8'hff));
    send_item(make_item(FUNC_INC, 1'b1, REG_A, 8'h00));
    wait_for_drain();

    // random traffic: idle, steady, idle after a full drain, steady tail
    for (int phase = 0; phase < 4; phase++) begin
      idle_on <= (phase == 0 || phase == 2);
      if (phase == 2) wait_for_drain();
      for (int n = 0; n < ITEM_COUNT / 4; n++) send_item(random_item());
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input transfers and %0d checked results", items_sent,
             result_count);
    $display("all sixteen function codes, memory slot, stall and idle bursts on both sides");
    if (fail_count == 0) begin
      $display("[accumulator_alu_with_register_file] OK");
    end else begin
      $display("[accumulator_alu_with_register_file] ERROR");
    end
    $finish;
  end

endmodule
